// File: hdl/zph_pkg.sv
// ----------------------------------------------------------------------------
// zph_pkg
// Shared types, constants and helpers for the Zobrist position hasher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package zph_pkg;

  // Default geometry; the first two are handed to the top level as parameter defaults.
  localparam int SQUARES_DEF     = 120;
  localparam int PIECE_CODES_DEF = 13;
  localparam int CASTLE_STATES   = 16;

  // Key generator (xorshift64*).
  localparam logic [63:0] GEN_SEED = 64'd1070372;
  localparam logic [63:0] GEN_MULT = 64'd2685821657736338717;

  // Piece codes that contribute.
  localparam int FIRST_PIECE = 1;
  localparam int LAST_PIECE  = 12;

  // Field widths.
  localparam int OP_W     = 2;
  localparam int SQUARE_W = 7;
  localparam int PIECE_W  = 4;
  localparam int COUNT_W  = 4;
  localparam int CASTLE_W = 4;
  localparam int KEY_W    = 64;
  localparam int IN_W     = 32;
  localparam int OUT_W    = 2 * KEY_W;

  // Op codes.
  localparam logic [OP_W-1:0] OP_PIECE    = 2'd0;
  localparam logic [OP_W-1:0] OP_FINISH   = 2'd1;
  localparam logic [OP_W-1:0] OP_MATERIAL = 2'd2;

  typedef enum logic [2:0] {
    G_SHIFT,
    G_MUL0,
    G_MUL1,
    G_MUL2,
    G_DONE
  } gen_phase_t;

  typedef enum logic [2:0] {
    S_FILL,
    S_IDLE,
    S_POS,
    S_MAT,
    S_FIN_CASTLE,
    S_FIN_SIDE,
    S_FIN_EP,
    S_EMIT
  } state_t;

  // Key generator status toward the key store.
  typedef struct packed {
    logic write;
    logic done;
  } fill_t;

  function automatic logic [63:0] xs64(input logic [63:0] s);
    logic [63:0] t;
    t = s ^ (s >> 12);
    t = t ^ (t << 25);
    t = t ^ (t >> 27);
    return t;
  endfunction

endpackage

`default_nettype wire

// File: hdl/zobrist_position_hasher.sv
// ----------------------------------------------------------------------------
// zobrist_position_hasher
// Builds Zobrist position and material keys from a stream of piece words.
// ----------------------------------------------------------------------------
// After reset the block fills its key store (one synchronous RAM of
// PIECE_CODES*SQUARES + 17 words of 64 bits) from an xorshift64* generator,
// one key at a time, and s_tready stays low until the fill is done. Then
// each input word is one op. A piece op XORs the key of (piece, square),
// once the registered RAM read returns it, into the position accumulator.
// A material op XORs the keys of counts 0..count-1 for that piece into the
// material accumulator, one RAM read per cycle. A finish op folds in the
// castling, side and en passant keys (three reads in turn), loads the
// output register and clears both accumulators, waiting first while an
// earlier result waits on m_tready. Ignored ops change nothing. The output
// register holds a result while the block goes on with new words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module zobrist_position_hasher #(
  parameter int SQUARES     = zph_pkg::SQUARES_DEF,
  parameter int PIECE_CODES = zph_pkg::PIECE_CODES_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  // input stream
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  // tdata, from bit 0: square[6:0], piece[10:7], count[14:11], ep_valid[15],
  // ep_square[22:16], side_white[23], castle_perm[27:24], zero pad [31:28]
  input  wire logic [zph_pkg::IN_W-1:0]  s_tdata,
  // tuser, from bit 0: op[1:0]
  input  wire logic [zph_pkg::OP_W-1:0]  s_tuser,
  // output stream
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  // tdata, from bit 0: position_key[63:0], material_key[127:64]
  output logic [zph_pkg::OUT_W-1:0]      m_tdata
);
  import zph_pkg::*;

  // store layout: piece-square keys code-major, castling keys, side key
  localparam int DEPTH = PIECE_CODES * SQUARES + CASTLE_STATES + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] SQ_A        = AW'(SQUARES);
  localparam logic [AW-1:0] CASTLE_BASE = AW'(PIECE_CODES * SQUARES);
  localparam logic [AW-1:0] SIDE_ADDR   = AW'(PIECE_CODES * SQUARES + CASTLE_STATES);

  // input fields
  logic [SQUARE_W-1:0] in_square, in_ep_square;
  logic [PIECE_W-1:0]  in_piece;
  logic [COUNT_W-1:0]  in_count;
  logic [CASTLE_W-1:0] in_castle;
  logic                in_ep_valid, in_side;

  assign in_square    = s_tdata[6:0];
  assign in_piece     = s_tdata[10:7];
  assign in_count     = s_tdata[14:11];
  assign in_ep_valid  = s_tdata[15];
  assign in_ep_square = s_tdata[22:16];
  assign in_side      = s_tdata[23];
  assign in_castle    = s_tdata[27:24];

  logic piece_ok, square_ok, ep_ok_in, accept;
  assign piece_ok  = int'(in_piece) >= FIRST_PIECE && int'(in_piece) <= LAST_PIECE
                     && int'(in_piece) < PIECE_CODES;
  assign square_ok = int'(in_square) < SQUARES;
  assign ep_ok_in  = in_ep_valid && (int'(in_ep_square) < SQUARES);
  assign accept    = s_tvalid && s_tready;

  // key generator and store
  fill_t             fill;
  logic [AW-1:0]     wr_addr;
  logic [KEY_W-1:0]  wr_data;

  zph_keygen #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_keygen (
    .clk     (clk),
    .rst     (rst),
    .fill    (fill),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  logic [KEY_W-1:0] key_mem [DEPTH];
  logic [AW-1:0]    rd_addr;
  logic [KEY_W-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (fill.write) key_mem[wr_addr] <= wr_data;
    rd_data <= key_mem[rd_addr];
  end

  // control
  state_t            state, state_next;
  logic [AW-1:0]     piece_base;
  logic [AW-1:0]     mat_base;
  logic [COUNT_W-1:0] mat_cnt, mat_idx;
  logic              fin_side, fin_ep;
  logic [SQUARE_W-1:0] fin_ep_sq;
  logic [KEY_W-1:0]  pos_acc, mat_acc;
  logic              out_free;

  assign piece_base = AW'(in_piece) * SQ_A;
  assign out_free   = !m_tvalid || m_tready;
  assign s_tready   = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_FILL;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_addr    = '0;
    unique case (state)
      S_FILL: if (fill.done) state_next = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          case (s_tuser)
            OP_PIECE: begin
              rd_addr = piece_base + AW'(in_square);
              if (piece_ok && square_ok) state_next = S_POS;
            end
            OP_MATERIAL: begin
              rd_addr = piece_base;
              if (piece_ok && in_count != '0) state_next = S_MAT;
            end
            OP_FINISH: begin
              rd_addr    = CASTLE_BASE + AW'(in_castle);
              state_next = S_FIN_CASTLE;
            end
            default: ;
          endcase
        end
      end
      S_POS: state_next = S_IDLE;
      S_MAT: begin
        rd_addr = mat_base + AW'(mat_idx);
        if (mat_idx >= mat_cnt) state_next = S_IDLE;
      end
      S_FIN_CASTLE: begin
        rd_addr    = SIDE_ADDR;
        state_next = S_FIN_SIDE;
      end
      S_FIN_SIDE: begin
        rd_addr    = AW'(fin_ep_sq);   // piece code 0 row
        state_next = S_FIN_EP;
      end
      S_FIN_EP: state_next = S_EMIT;
      S_EMIT: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // latched operands (payload)
  always_ff @(posedge clk) begin
    if (accept) begin
      mat_base  <= piece_base;
      mat_cnt   <= in_count;
      fin_side  <= in_side;
      fin_ep    <= ep_ok_in;
      fin_ep_sq <= in_ep_square;
    end
    if (accept) begin
      mat_idx <= COUNT_W'(1);
    end else if (state == S_MAT && mat_idx < mat_cnt) begin
      mat_idx <= mat_idx + 1'b1;
    end
  end

  // accumulators and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_acc  <= '0;
      mat_acc  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // a new result may replace one taken at this same edge
      if (state == S_EMIT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_POS:        pos_acc <= pos_acc ^ rd_data;
        S_MAT:        mat_acc <= mat_acc ^ rd_data;
        S_FIN_CASTLE: pos_acc <= pos_acc ^ rd_data;
        S_FIN_SIDE:   if (fin_side) pos_acc <= pos_acc ^ rd_data;
        S_FIN_EP:     if (fin_ep) pos_acc <= pos_acc ^ rd_data;
        S_EMIT: begin
          if (out_free) begin
            pos_acc  <= '0;
            mat_acc  <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) m_tdata <= {mat_acc, pos_acc};
  end

endmodule

`default_nettype wire

// File: hdl/zph_keygen.sv
// ----------------------------------------------------------------------------
// zph_keygen
// Draws xorshift64* keys after reset and writes them to the key store in
// address order, computing each key on one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module zph_keygen #(
  parameter int DEPTH = 1577,
  parameter int AW    = 11
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  output zph_pkg::fill_t              fill,
  output logic [AW-1:0]               wr_addr,
  output logic [zph_pkg::KEY_W-1:0]   wr_data
);
  import zph_pkg::*;

  gen_phase_t       phase, phase_next;
  logic [63:0]      seed;
  logic [63:0]      prod;
  logic [AW-1:0]    idx;
  logic [31:0]      mul_a, mul_b;
  logic [63:0]      mul_p;
  logic             last;

  assign last  = (idx == AW'(DEPTH - 1));
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= G_SHIFT;
    end else begin
      phase <= phase_next;
    end
  end

  always_comb begin
    phase_next = phase;
    fill       = '0;
    mul_a      = seed[31:0];
    mul_b      = GEN_MULT[31:0];
    unique case (phase)
      G_SHIFT: phase_next = G_MUL0;
      G_MUL0:  phase_next = G_MUL1;
      G_MUL1: begin
        mul_a      = seed[63:32];
        phase_next = G_MUL2;
      end
      G_MUL2: begin
        mul_b      = GEN_MULT[63:32];
        fill.write = 1'b1;
        phase_next = last ? G_DONE : G_SHIFT;
      end
      G_DONE:  fill.done = 1'b1;
      default: phase_next = G_SHIFT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= GEN_SEED;
      idx  <= '0;
    end else begin
      if (phase == G_SHIFT) seed <= xs64(seed);
      if (phase == G_MUL2 && !last) idx <= idx + 1'b1;
    end
  end

  // low 64 bits of seed * mult from three partial products
  always_ff @(posedge clk) begin
    case (phase)
      G_MUL0:  prod <= mul_p;
      G_MUL1:  prod[63:32] <= prod[63:32] + mul_p[31:0];
      default: ;
    endcase
  end

  assign wr_addr = idx;
  assign wr_data = {prod[63:32] + mul_p[31:0], prod[31:0]};

endmodule

`default_nettype wire

// File: hdl/zph_checker.sv
// ----------------------------------------------------------------------------
// zph_checker
// Port-level checks for the Zobrist position hasher, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module zph_checker (
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     s_tvalid,
  input wire logic                     s_tready,
  input wire logic [zph_pkg::IN_W-1:0] s_tdata,
  input wire logic [zph_pkg::OP_W-1:0] s_tuser,
  input wire logic                     m_tvalid,
  input wire logic                     m_tready,
  input wire logic [zph_pkg::OUT_W-1:0] m_tdata
);
  import zph_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // out of reset: key fill running, nothing to send
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid && !s_tready)
    else $error("block not quiet after reset");

  // a finish op keeps the input closed while its keys are read
  a_finish_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == OP_FINISH |=> !s_tready)
    else $error("input reopened during finish");

  // a new result shows up exactly as the block returns to idle
  a_emit_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> s_tready && $past(!s_tready))
    else $error("result without a completed finish");

endmodule

bind zobrist_position_hasher zph_checker u_zph_checker (.*);

`default_nettype wire
